// ===== src/spq_pkg.sv =====
// shared constants and types of the strict priority task queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int LEVELS_DEF       = 10;
  localparam int DEPTH_DEF        = 16;
  localparam int HANDLE_W_DEF     = 32;

  localparam int BUCKET_SPAN      = 10;
  localparam int IMP_W            = 16;
  localparam int HANDLE_PORT_W    = 32;
  localparam int HANDLE_MAX_W     = 48;
  localparam int LEVEL_OUT_W      = 4;
  localparam int TOTAL_W          = 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic [LEVEL_OUT_W-1:0]   level;
    logic [TOTAL_W-1:0]       total;
  } result_meta_t;

endpackage

// ===== src/spq_store.sv =====
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module spq_store #(
  parameter int SLOTS = spq_pkg::LEVELS_DEF * spq_pkg::DEPTH_DEF,
  parameter int EW    = spq_pkg::HANDLE_W_DEF + spq_pkg::IMP_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  logic [EW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output logic [EW-1:0]            rdata
);

  logic [EW-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/strict_priority_task_queue.sv =====
// strict priority task queue: per-level fifos in one entry memory
//
//   channel   dir   word                                   accepted when
//   s_axis    in    push or pop request                    tvalid & tready
//   m_axis    out   status, handle, importance, level,     tvalid & tready
//                   total count
//
// one word accepted per cycle when the output side keeps up
// a result passes the s1 stage and the output register before it shows on m_axis;
// the s1 stage covers the read of the entry memory for a pop
// head, tail and count registers of each level clear on reset at once;
// the entry memory is not cleared, only written entries are ever read
// a stalled output holds one result and one in flight, then s_axis stalls
`timescale 1ns / 1ps

module strict_priority_task_queue #(
  parameter int LEVELS          = spq_pkg::LEVELS_DEF,
  parameter int DEPTH_PER_LEVEL = spq_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH    = spq_pkg::HANDLE_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // task_handle[31:0], importance[47:32]
  input  logic [0:0]  s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_handle[31:0], out_importance[47:32],
                                      // level_used[51:48], total_count[59:52], zero
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int LW    = $clog2(LEVELS);
  localparam int IW    = $clog2(DEPTH_PER_LEVEL);
  localparam int CW    = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int SLOTS = LEVELS * DEPTH_PER_LEVEL;
  localparam int AW    = $clog2(SLOTS);
  localparam int IMPW  = spq_pkg::IMP_W;
  localparam int EW    = HANDLE_WIDTH + IMPW;
  localparam int HPW   = spq_pkg::HANDLE_PORT_W;
  localparam int HMW   = spq_pkg::HANDLE_MAX_W;
  localparam int LOW   = spq_pkg::LEVEL_OUT_W;
  localparam int TW    = spq_pkg::TOTAL_W;

  // request fields
  logic             cmd;
  logic [HPW-1:0]   in_handle;
  logic [IMPW-1:0]  in_imp;

  assign cmd       = s_axis_tuser[0];
  assign in_handle = s_axis_tdata[HPW-1:0];
  assign in_imp    = s_axis_tdata[HPW+IMPW-1:HPW];

  // per-level bookkeeping
  logic [IW-1:0] head  [LEVELS];
  logic [IW-1:0] tail  [LEVELS];
  logic [CW-1:0] count [LEVELS];
  logic [TW-1:0] total;
  logic [TW-1:0] total_next;

  // pipeline stage waiting for memory read data
  logic                  s1_valid;
  spq_pkg::result_meta_t s1_meta;
  spq_pkg::result_meta_t meta_next;
  logic                  s1_move;

  // output register
  logic                  out_valid;
  spq_pkg::status_t      out_status;
  logic [HPW-1:0]        out_handle;
  logic [IMPW-1:0]       out_importance;
  logic [LOW-1:0]        level_used;
  logic [TW-1:0]         total_count;

  logic          accept;
  logic [LW-1:0] bucket;
  logic [LW-1:0] push_lvl;
  logic [LW-1:0] pop_lvl;
  logic          pop_found;
  logic [LW-1:0] sel_lvl;
  logic [CW-1:0] cur_count;
  logic [IW-1:0] cur_head;
  logic [IW-1:0] cur_tail;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;
  logic          push_ok;
  logic          do_push;
  logic          do_pop;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic [HMW-1:0] handle_wide_in;
  logic [HMW-1:0] handle_wide_out;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s1_move       = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_move;

  // bucket is the highest step of the span reached, clamped to the top level
  always_comb begin
    bucket = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if (!in_imp[IMPW-1] && (in_imp >= IMPW'(k * spq_pkg::BUCKET_SPAN))) begin
        bucket = LW'(k);
      end
    end
    push_lvl = LW'(LEVELS - 1) - bucket;
  end

  // lowest-numbered non-empty level
  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count[l] != '0) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(l);
      end
    end
  end

  assign sel_lvl   = (cmd == spq_pkg::CMD_POP) ? pop_lvl : push_lvl;
  assign cur_count = count[sel_lvl];
  assign cur_head  = head[sel_lvl];
  assign cur_tail  = tail[sel_lvl];
  assign head_next = (cur_head == IW'(DEPTH_PER_LEVEL - 1)) ? '0 : cur_head + 1'b1;
  assign tail_next = (cur_tail == IW'(DEPTH_PER_LEVEL - 1)) ? '0 : cur_tail + 1'b1;
  assign push_ok   = (cur_count != CW'(DEPTH_PER_LEVEL));
  assign do_push   = accept && (cmd == spq_pkg::CMD_PUSH) && push_ok;
  assign do_pop    = accept && (cmd == spq_pkg::CMD_POP) && pop_found;

  assign handle_wide_in = HMW'(in_handle);

  assign mem_we    = do_push;
  assign mem_waddr = AW'(push_lvl) * AW'(DEPTH_PER_LEVEL) + AW'(cur_tail);
  assign mem_wdata = {handle_wide_in[HANDLE_WIDTH-1:0], in_imp};
  assign mem_re    = do_pop;
  assign mem_raddr = AW'(pop_lvl) * AW'(DEPTH_PER_LEVEL) + AW'(cur_head);

  spq_store #(
    .SLOTS (SLOTS),
    .EW    (EW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // total is kept modulo the width of the reported count
  always_comb begin
    total_next = total;
    if (do_push) begin
      total_next = total + 1'b1;
    end else if (do_pop) begin
      total_next = total - 1'b1;
    end
  end

  always_comb begin
    meta_next.total = total_next;
    if (cmd == spq_pkg::CMD_PUSH) begin
      meta_next.status = push_ok ? spq_pkg::ST_PUSHED : spq_pkg::ST_DROPPED;
      meta_next.level  = LOW'(push_lvl);
    end else if (pop_found) begin
      meta_next.status = spq_pkg::ST_POPPED;
      meta_next.level  = LOW'(pop_lvl);
    end else begin
      meta_next.status = spq_pkg::ST_EMPTY;
      meta_next.level  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
      total     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_push) begin
        tail[push_lvl]  <= tail_next;
        count[push_lvl] <= cur_count + 1'b1;
      end
      if (do_pop) begin
        head[pop_lvl]  <= head_next;
        count[pop_lvl] <= cur_count - 1'b1;
      end
      total <= total_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
    end
  end

  assign handle_wide_out = HMW'(mem_rdata[EW-1:IMPW]);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_next;
    end
    if (s1_move && s1_valid) begin
      out_status  <= s1_meta.status;
      level_used  <= s1_meta.level;
      total_count <= s1_meta.total;
      if (s1_meta.status == spq_pkg::ST_POPPED) begin
        out_handle     <= handle_wide_out[HPW-1:0];
        out_importance <= mem_rdata[IMPW-1:0];
      end else begin
        out_handle     <= '0;
        out_importance <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {4'b0, total_count, level_used, out_importance, out_handle};

endmodule

// ===== sim/tb_top.sv =====
// testbench of the strict priority task queue: random and directed push/pop traffic
`timescale 1ns / 1ps

module tb_top;

  localparam int NLEV = spq_pkg::LEVELS_DEF;
  localparam int NDEPTH = spq_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int IMP_W = spq_pkg::IMP_W;
  localparam int SPAN = spq_pkg::BUCKET_SPAN;

  typedef struct packed {
    spq_pkg::status_t                  status;
    logic [spq_pkg::HANDLE_PORT_W-1:0] handle;
    logic [spq_pkg::IMP_W-1:0]         imp;
    logic [spq_pkg::LEVEL_OUT_W-1:0]   level;
    logic [spq_pkg::TOTAL_W-1:0]       total;
  } task_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;    // task_handle[31:0], importance[47:32]
  logic [0:0]  s_axis_tuser = '0;    // command[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // out_handle[31:0], out_importance[47:32],
                                     // level_used[51:48], total_count[59:52], zero
  logic [1:0]  m_axis_tuser;         // status[1:0]

  int unsigned src_idle_pct = 31;
  int unsigned sink_idle_pct = 82;
  int unsigned hold_off_len = 0;
  int          fail_count = 0;

  // entries held per level, oldest first: {importance, handle}
  logic [IMP_W+spq_pkg::HANDLE_PORT_W-1:0] level_fifo[NLEV][$];
  task_result_t expected_results[$];

  strict_priority_task_queue dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // high importance maps to level 0, negatives to the bottom level
  function automatic int level_for(logic [IMP_W-1:0] imp);
    int bucket;
    bucket = 0;
    if (!imp[IMP_W-1]) bucket = int'(imp) / SPAN;
    if (bucket > NLEV - 1) bucket = NLEV - 1;
    return NLEV - 1 - bucket;
  endfunction

  function automatic logic [IMP_W-1:0] importance_for_level(int lvl);
    int bucket;
    bucket = NLEV - 1 - lvl;
    if (bucket == NLEV - 1) return 16'($urandom_range(32767, (NLEV - 1) * SPAN));
    if (bucket == 0 && $urandom_range(1) == 1) return 16'(-int'($urandom_range(32768, 1)));
    return 16'(bucket * SPAN + int'($urandom_range(SPAN - 1)));
  endfunction

  function automatic task_result_t predict_queue_result(logic cmd, logic [31:0] handle,
                                                        logic [IMP_W-1:0] imp);
    task_result_t r;
    int lvl;
    int held;
    r = '0;
    r.status = spq_pkg::ST_EMPTY;
    if (cmd == spq_pkg::CMD_PUSH) begin
      lvl = level_for(imp);
      r.level = spq_pkg::LEVEL_OUT_W'(lvl);
      if (level_fifo[lvl].size() >= NDEPTH) begin
        r.status = spq_pkg::ST_DROPPED;
      end else begin
        level_fifo[lvl].push_back({imp, handle});
        r.status = spq_pkg::ST_PUSHED;
      end
    end else begin
      lvl = -1;
      for (int i = 0; i < NLEV; i++)
        if (lvl < 0 && level_fifo[i].size() != 0) lvl = i;
      if (lvl >= 0) begin
        {r.imp, r.handle} = level_fifo[lvl].pop_front();
        r.level = spq_pkg::LEVEL_OUT_W'(lvl);
        r.status = spq_pkg::ST_POPPED;
      end
    end
    held = 0;
    for (int i = 0; i < NLEV; i++) held += level_fifo[i].size();
    r.total = spq_pkg::TOTAL_W'(held);
    return r;
  endfunction

  task automatic issue_request(input logic cmd, input logic [31:0] handle,
                               input logic [IMP_W-1:0] imp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {imp, handle};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_queue_result(cmd, handle, imp));
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // bucket edges, sign extremes, handle extremes, pop on empty queue
  task automatic test_level_mapping();
    logic [IMP_W-1:0] marks [10] = '{16'h7fff, 16'h8000, 16'd0, 16'd9, 16'd10,
                                     16'd89, 16'd90, 16'hffff, 16'd99, 16'd100};
    issue_request(spq_pkg::CMD_POP, $urandom, 16'($urandom));
    issue_request(spq_pkg::CMD_PUSH, 32'h0, marks[0]);
    issue_request(spq_pkg::CMD_PUSH, 32'hffff_ffff, marks[1]);
    for (int i = 2; i < 10; i++) issue_request(spq_pkg::CMD_PUSH, $urandom, marks[i]);
    // pops carry junk in handle and importance
    repeat (11) issue_request(spq_pkg::CMD_POP, $urandom, 16'($urandom));
  endtask

  // every level gets its depth plus one pushes, so it fills and drops, then drain past empty
  task automatic test_full_capacity();
    for (int lvl = 0; lvl < NLEV; lvl++)
      repeat (NDEPTH + 1)
        issue_request(spq_pkg::CMD_PUSH, $urandom, importance_for_level(lvl));
    repeat (NLEV * NDEPTH + 1) issue_request(spq_pkg::CMD_POP, $urandom, 16'($urandom));
  endtask

  // push-heavy and pop-heavy bursts so levels fill, wrap and drain
  task automatic test_random_traffic(int count);
    int push_pct;
    int burst_left;
    logic [IMP_W-1:0] imp;
    push_pct = 50;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 10);
        push_pct = ($urandom_range(1) == 1) ? 80 : 25;
      end
      burst_left--;
      if ($urandom_range(99) < 70) imp = importance_for_level($urandom_range(NLEV - 1));
      else imp = 16'($urandom);
      if ($urandom_range(99) < push_pct) issue_request(spq_pkg::CMD_PUSH, $urandom, imp);
      else issue_request(spq_pkg::CMD_POP, $urandom, imp);
    end
  endtask

  // long output stall while requests keep coming, input must back up
  task automatic test_output_backpressure();
    hold_off_len = 150;
    repeat (24) begin
      if ($urandom_range(1) == 1)
        issue_request(spq_pkg::CMD_PUSH, $urandom,
                      importance_for_level($urandom_range(NLEV - 1)));
      else
        issue_request(spq_pkg::CMD_POP, $urandom, 16'($urandom));
    end
  endtask

  initial begin : result_checker
    task_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request waiting: tdata 0x%0h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("out_handle", want.handle, m_axis_tdata[31:0]);
          check_field("out_importance", want.imp, m_axis_tdata[47:32]);
          check_field("level_used", want.level, m_axis_tdata[51:48]);
          check_field("total_count", want.total, m_axis_tdata[59:52]);
        end
      end
      if (hold_off_len != 0) begin
        m_axis_tready <= 1'b0;
        hold_off_len--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_level_mapping();
    test_random_traffic(170);

    src_idle_pct = 82;
    sink_idle_pct = 31;
    test_full_capacity();
    test_random_traffic(150);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(160);
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
